/* rtl/y2rgb_pkg.sv */
// Package with constants, types and helpers for the YUY2 pair to RGB converter.
package y2rgb_pkg;

  // Widths of the data path.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LUMA_W  = 24;  // luma scaled to bits 23..0
  localparam int unsigned CHROMA_W = 9;  // signed chroma, -128..127
  localparam int unsigned COEF_W  = 18;  // signed coefficient width
  localparam int unsigned SUM_W   = 27;  // signed products and sums

  // Fixed-point conversion constants, 16 fractional bits.
  localparam logic [CHROMA_W-1:0]      CHROMA_MID = 9'd128;
  localparam logic signed [COEF_W-1:0] COEF_G_CB  = 18'sd22554;
  localparam logic signed [COEF_W-1:0] COEF_G_CR  = 18'sd46802;
  localparam logic signed [COEF_W-1:0] COEF_B_CB  = 18'sd116130;
  localparam logic signed [COEF_W-1:0] COEF_R_CR  = 18'sd91881;

  typedef logic signed [SUM_W-1:0] sum_t;

  // Scale a luma byte by 0x10101, which replicates it into three bytes.
  function automatic logic [LUMA_W-1:0] scale_luma(input logic [BYTE_W-1:0] y);
    return {y, y, y};
  endfunction

  // Make an offset-binary chroma byte signed around zero.
  function automatic logic signed [CHROMA_W-1:0] center_chroma(
    input logic [BYTE_W-1:0] c
  );
    return $signed({1'b0, c} - CHROMA_MID);
  endfunction

  // Clamp a sum to one byte: negative gives 0, 2^24 or more gives 255.
  function automatic logic [BYTE_W-1:0] clamp_channel(input sum_t s);
    logic [BYTE_W-1:0] res;
    if (s[SUM_W-1]) begin
      res = '0;
    end else if (s[SUM_W-2:LUMA_W] != '0) begin
      res = '1;
    end else begin
      res = s[LUMA_W-1:LUMA_W-BYTE_W];
    end
    return res;
  endfunction

endpackage

/* rtl/yuyv_pair_to_rgb.sv */
// An accepted input transaction reaches out_tdata after passing each of the stages listed below.
// Throughput: one pixel pair per cycle; the four stages advance together when the
// output register is empty or out_tready is high, so a stall holds every stage.
// Stages: input register, constant multipliers, channel sums, clamp into output.
// Reset: rst_n is synchronous and active low; it clears all stage valid bits.
module yuyv_pair_to_rgb
  import y2rgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input: luma_first [7:0], chroma_blue [15:8], luma_second [23:16],
  // chroma_red [31:24].
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  // Output: red_first [7:0], green_first [15:8], blue_first [23:16],
  // red_second [31:24], green_second [39:32], blue_second [47:40].
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata
);

  // Pipeline advance enable shared by every stage.
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // Valid bits of the four stages.
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_tvalid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  // Stage 1: register the scaled lumas and the centered chroma.
  logic [LUMA_W-1:0]          y0_s1_r, y1_s1_r;
  logic signed [CHROMA_W-1:0] cb_s1_r, cr_s1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      y0_s1_r <= scale_luma(in_tdata[7:0]);
      cb_s1_r <= center_chroma(in_tdata[15:8]);
      y1_s1_r <= scale_luma(in_tdata[23:16]);
      cr_s1_r <= center_chroma(in_tdata[31:24]);
    end
  end

  // Stage 2: one constant multiplier per chroma term.
  logic [LUMA_W-1:0] y0_s2_r, y1_s2_r;
  sum_t r_off_s2_r, b_off_s2_r, g_cb_s2_r, g_cr_s2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      y0_s2_r    <= y0_s1_r;
      y1_s2_r    <= y1_s1_r;
      r_off_s2_r <= cr_s1_r * COEF_R_CR;
      b_off_s2_r <= cb_s1_r * COEF_B_CB;
      g_cb_s2_r  <= cb_s1_r * COEF_G_CB;
      g_cr_s2_r  <= cr_s1_r * COEF_G_CR;
    end
  end

  // Stage 3: the six channel sums.
  sum_t y0_ext, y1_ext;
  assign y0_ext = $signed({{(SUM_W-LUMA_W){1'b0}}, y0_s2_r});
  assign y1_ext = $signed({{(SUM_W-LUMA_W){1'b0}}, y1_s2_r});

  sum_t r0_s3_r, g0_s3_r, b0_s3_r, r1_s3_r, g1_s3_r, b1_s3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      r0_s3_r <= y0_ext + r_off_s2_r;
      g0_s3_r <= y0_ext - g_cb_s2_r - g_cr_s2_r;
      b0_s3_r <= y0_ext + b_off_s2_r;
      r1_s3_r <= y1_ext + r_off_s2_r;
      g1_s3_r <= y1_ext - g_cb_s2_r - g_cr_s2_r;
      b1_s3_r <= y1_ext + b_off_s2_r;
    end
  end

  // Stage 4: clamp each channel into the output register.
  logic [47:0] out_data_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {clamp_channel(b1_s3_r), clamp_channel(g1_s3_r),
                     clamp_channel(r1_s3_r), clamp_channel(b0_s3_r),
                     clamp_channel(g0_s3_r), clamp_channel(r0_s3_r)};
    end
  end

  assign out_tvalid = s4_vld_r;
  assign out_tdata  = out_data_r;

endmodule

/* rtl/yuyv_pair_to_rgb_chk.sv */
// Port-level checker for the YUY2 pair to RGB converter and its bind.
module yuyv_pair_to_rgb_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // A stalled result transaction stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped during a stall");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed during a stall");

  // An empty output register never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // The pipeline advances whenever the result side takes data.
  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output ready");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

endmodule

bind yuyv_pair_to_rgb yuyv_pair_to_rgb_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
